FILE: hw/rtl/tcpop_pkg.sv
// tcp option parser package: word types, option kinds, status codes, parse phases
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcpop_pkg;

  localparam logic [7:0] OPT_END = 8'd0;
  localparam logic [7:0] OPT_NOP = 8'd1;
  localparam logic [7:0] OPT_MSS = 8'd2;
  localparam logic [7:0] MSS_LEN = 8'd4;
  localparam logic [7:0] MIN_LEN = 8'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MSS_LEN = 2'd1,
    ST_BAD_LEN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_KIND  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] opt_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        mss_found;
    logic [15:0] mss_value;
  } out_word_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tcp_option_parser.sv
// tcp option parser top level: byte-wide option walker with a registered result
// depends on tcpop_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes the option area of one TCP header one byte per word, with last_byte set
// on the final byte, and walks kind/length/value records. One byte is accepted
// every cycle unless the input stalls; the parse state updates in the cycle
// the byte is taken, and the result for an area appears in the output register
// in the cycle after its final byte. Input stalls only while a result sits in
// the output register and the output side is stalling. After each final byte
// the parser is ready for the next area with no gap.
module tcp_option_parser (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire tcpop_pkg::in_word_t in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output tcpop_pkg::out_word_t out_data
);

  tcpop_pkg::phase_t    phase_r, phase_nxt;
  logic [7:0]           bytes_left_r, bytes_left_nxt;
  logic                 kind_is_mss_r, kind_is_mss_nxt;
  logic [7:0]           mss_high_r, mss_high_nxt;
  logic [15:0]          mss_word_r, mss_word_nxt;
  logic                 mss_seen_r, mss_seen_nxt;
  tcpop_pkg::status_t   error_r, error_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tcpop_pkg::out_word_t out_data_r, out_data_nxt;

  logic                 take;
  logic [7:0]           len_rem;
  logic [7:0]           b;

  assign in_stall  = out_valid_r & out_stall;
  assign take      = in_valid & ~in_stall;
  assign b         = in_data.opt_byte;
  assign len_rem   = b - tcpop_pkg::MIN_LEN;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      tcpop_pkg::PH_KIND: begin
        if (b == tcpop_pkg::OPT_END) begin
          phase_nxt = tcpop_pkg::PH_DONE;
        end else if (b != tcpop_pkg::OPT_NOP) begin
          phase_nxt = tcpop_pkg::PH_LEN;
        end
      end
      tcpop_pkg::PH_LEN: begin
        if (kind_is_mss_r && b != tcpop_pkg::MSS_LEN) begin
          phase_nxt = tcpop_pkg::PH_DONE;
        end else if (b < tcpop_pkg::MIN_LEN) begin
          phase_nxt = tcpop_pkg::PH_DONE;
        end else if (len_rem == 8'd0) begin
          phase_nxt = tcpop_pkg::PH_KIND;
        end else begin
          phase_nxt = tcpop_pkg::PH_VALUE;
        end
      end
      tcpop_pkg::PH_VALUE: begin
        if (bytes_left_r == 8'd1) begin
          phase_nxt = tcpop_pkg::PH_KIND;
        end
      end
      default: phase_nxt = phase_r;
    endcase
    if (!take) begin
      phase_nxt = phase_r;
    end else if (in_data.last_byte) begin
      phase_nxt = tcpop_pkg::PH_KIND;
    end
  end

  // datapath and result
  always_comb begin
    bytes_left_nxt  = bytes_left_r;
    kind_is_mss_nxt = kind_is_mss_r;
    mss_high_nxt    = mss_high_r;
    mss_word_nxt    = mss_word_r;
    mss_seen_nxt    = mss_seen_r;
    error_nxt       = error_r;
    case (phase_r)
      tcpop_pkg::PH_KIND: begin
        if (b != tcpop_pkg::OPT_END && b != tcpop_pkg::OPT_NOP) begin
          kind_is_mss_nxt = (b == tcpop_pkg::OPT_MSS);
        end
      end
      tcpop_pkg::PH_LEN: begin
        if (kind_is_mss_r && b != tcpop_pkg::MSS_LEN) begin
          error_nxt = tcpop_pkg::ST_MSS_LEN;
        end else if (b < tcpop_pkg::MIN_LEN) begin
          error_nxt = tcpop_pkg::ST_BAD_LEN;
        end else begin
          bytes_left_nxt = len_rem;
        end
      end
      tcpop_pkg::PH_VALUE: begin
        if (kind_is_mss_r && bytes_left_r == 8'd2) begin
          mss_high_nxt = b;
        end
        if (kind_is_mss_r && bytes_left_r == 8'd1) begin
          mss_word_nxt = {mss_high_r, b};
          mss_seen_nxt = 1'b1;
        end
        bytes_left_nxt = bytes_left_r - 8'd1;
      end
      default: bytes_left_nxt = bytes_left_r;
    endcase

    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (take && in_data.last_byte) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.status    = error_nxt;
      out_data_nxt.mss_found = mss_seen_nxt;
      out_data_nxt.mss_value = mss_seen_nxt ? mss_word_nxt : 16'd0;
    end

    if (!take) begin
      bytes_left_nxt  = bytes_left_r;
      kind_is_mss_nxt = kind_is_mss_r;
      mss_high_nxt    = mss_high_r;
      mss_word_nxt    = mss_word_r;
      mss_seen_nxt    = mss_seen_r;
      error_nxt       = error_r;
    end else if (in_data.last_byte) begin
      bytes_left_nxt  = 8'd0;
      kind_is_mss_nxt = 1'b0;
      mss_high_nxt    = 8'd0;
      mss_word_nxt    = 16'd0;
      mss_seen_nxt    = 1'b0;
      error_nxt       = tcpop_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= tcpop_pkg::PH_KIND;
      bytes_left_r  <= 8'd0;
      kind_is_mss_r <= 1'b0;
      mss_high_r    <= 8'd0;
      mss_word_r    <= 16'd0;
      mss_seen_r    <= 1'b0;
      error_r       <= tcpop_pkg::ST_OK;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      kind_is_mss_r <= kind_is_mss_nxt;
      mss_high_r    <= mss_high_nxt;
      mss_word_r    <= mss_word_nxt;
      mss_seen_r    <= mss_seen_nxt;
      error_r       <= error_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
